@@ rtl/assert_macros.svh @@
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SSBD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define SSBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/ssbd_pkg.sv @@
// shared constants, types and twiddle table of the swipe button detector
package ssbd_pkg;

  localparam int CHANNELS = 4;
  localparam int MAX_CH   = 4;
  localparam int CH_W     = 2;
  localparam int WIN_LEN  = 32;
  localparam int SMP_W    = 32;
  localparam int ACT_W    = 32;
  localparam int ACC_W    = 55;
  localparam int MAG_W    = 54;
  localparam int HALF_W   = 27;
  localparam int SUM_W    = 108;
  localparam int REM_W    = 56;
  localparam int MULA_W   = 33;
  localparam int MULB_W   = 28;
  localparam int PROD_W   = 61;
  localparam int CNT_W    = 7;
  localparam int IN_W     = 128;
  localparam int OUT_W    = 144;
  localparam int PADDR_W  = 3;

  localparam logic [CNT_W-1:0] DFT_STEPS  = 7'd64;
  localparam logic [CNT_W-1:0] SQR_STEPS  = 7'd6;
  localparam logic [CNT_W-1:0] ROOT_LAST  = 7'd53;
  localparam logic [31:0]      THRESH_RESET = 32'd8000;

  localparam logic [5:0] FILL_FULL = 6'd32;
  localparam logic [5:0] FILL_LAST = 6'd31;

  // register indexes of the configuration port
  localparam logic [0:0] REG_THRESH = 1'b0;

  // quarter wave of cos in Q16
  localparam logic signed [17:0] QCOS [5] = '{18'sd65536, 18'sd60547, 18'sd46341,
                                              18'sd25080, 18'sd0};

  typedef enum logic [2:0] {
    LN_IDLE,
    LN_DFT,
    LN_SQR,
    LN_ROOT,
    LN_DONE
  } lane_state_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_MERGE
  } top_state_e;

  typedef struct packed {
    logic [MAX_CH-1:0] buttons;
    logic [MAX_CH-1:0] toggled;
    logic              lamp;
  } merge_res_t;

  function automatic logic signed [17:0] q16_cos(input logic [3:0] n);
    logic [3:0] m;
    logic       neg;
    if (n <= 4'd4) begin
      m = n;
      neg = 1'b0;
    end else if (n <= 4'd8) begin
      m = 4'd8 - n;
      neg = 1'b1;
    end else if (n <= 4'd12) begin
      m = n - 4'd8;
      neg = 1'b1;
    end else begin
      m = 4'd0 - n;
      neg = 1'b0;
    end
    return neg ? -QCOS[m[2:0]] : QCOS[m[2:0]];
  endfunction

endpackage

@@ rtl/ssbd_lane.sv @@
// one channel: sample window, bin 15 sum, squaring and square root
module ssbd_lane import ssbd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SMP_W-1:0] sample_i,
  output logic             done_o,
  output logic [ACT_W-1:0] act_o
);

  lane_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [SMP_W-1:0] win_q [WIN_LEN];
  logic signed [ACC_W-1:0] re_q, im_q;
  logic [SUM_W-1:0] sum_q;
  logic [REM_W-1:0] rem_q;
  logic [MAG_W-1:0] root_q;

  logic signed [PROD_W-1:0] prod_q;
  logic prod_vld_q, prod_dft_q;
  logic [1:0] prod_sel_q;

  logic signed [MULA_W-1:0] mul_a;
  logic signed [MULB_W-1:0] mul_b;
  logic issue, is_dft;
  logic [1:0] sel;
  logic signed [17:0] cosv, sinv;
  logic [MAG_W-1:0] mag_re, mag_im, mag;
  logic [HALF_W-1:0] hi, lo;
  logic [REM_W+1:0] rem_sh, trial;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    case (state_q)
      LN_IDLE: begin
        if (start_i) begin
          state_d = LN_DFT;
          cnt_d = '0;
        end
      end
      LN_DFT: begin
        if (cnt_q == DFT_STEPS) begin
          state_d = LN_SQR;
          cnt_d = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      LN_SQR: begin
        if (cnt_q == SQR_STEPS) begin
          state_d = LN_ROOT;
          cnt_d = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      LN_ROOT: begin
        if (cnt_q == ROOT_LAST) begin
          state_d = LN_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      LN_DONE: begin
        state_d = LN_IDLE;
      end
      default: begin
        state_d = LN_IDLE;
      end
    endcase
  end

  always_comb begin
    done_o = (state_q == LN_DONE);
    act_o = (root_q[MAG_W-1:48] != '0) ? '1 : root_q[47:16];
  end

  // operand selection for the shared multiplier
  always_comb begin
    cosv = q16_cos(cnt_q[5:2]);
    sinv = q16_cos(cnt_q[5:2] + 4'd12);
    mag_re = re_q[ACC_W-1] ? MAG_W'(-re_q) : MAG_W'(re_q);
    mag_im = im_q[ACC_W-1] ? MAG_W'(-im_q) : MAG_W'(im_q);
    mag = (cnt_q < 7'd3) ? mag_re : mag_im;
    hi = mag[MAG_W-1:HALF_W];
    lo = mag[HALF_W-1:0];
    is_dft = (state_q == LN_DFT);
    issue = (is_dft && cnt_q < DFT_STEPS) || (state_q == LN_SQR && cnt_q < SQR_STEPS);
    mul_a = '0;
    mul_b = '0;
    sel = cnt_q[1:0];
    if (is_dft) begin
      case (cnt_q[1:0])
        2'd0: begin
          mul_a = {1'b0, win_q[0]};
          mul_b = MULB_W'(cosv);
        end
        2'd1: begin
          mul_a = {1'b0, win_q[1]};
          mul_b = MULB_W'(sinv);
        end
        2'd2: begin
          mul_a = {1'b0, win_q[0]};
          mul_b = MULB_W'(sinv);
        end
        default: begin
          mul_a = {1'b0, win_q[1]};
          mul_b = MULB_W'(cosv);
        end
      endcase
    end else begin
      case (cnt_q)
        7'd0, 7'd3: begin
          mul_a = MULA_W'(hi);
          mul_b = MULB_W'(hi);
          sel = 2'd0;
        end
        7'd1, 7'd4: begin
          mul_a = MULA_W'(hi);
          mul_b = MULB_W'(lo);
          sel = 2'd1;
        end
        default: begin
          mul_a = MULA_W'(lo);
          mul_b = MULB_W'(lo);
          sel = 2'd2;
        end
      endcase
    end
    rem_sh = {rem_q, sum_q[SUM_W-1:SUM_W-2]};
    trial = {2'b00, root_q, 2'b01};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LN_IDLE;
      cnt_q <= '0;
      prod_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      prod_vld_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    prod_dft_q <= is_dft;
    prod_sel_q <= sel;
    if (state_q == LN_IDLE && start_i) begin
      for (int i = 0; i < WIN_LEN - 1; i++) win_q[i] <= win_q[i+1];
      win_q[WIN_LEN-1] <= sample_i;
      re_q <= '0;
      im_q <= '0;
      sum_q <= '0;
      rem_q <= '0;
      root_q <= '0;
    end
    // rotate by one pair so the next pair sits at the head
    if (is_dft && cnt_q < DFT_STEPS && cnt_q[1:0] == 2'd3) begin
      for (int i = 0; i < WIN_LEN - 2; i++) win_q[i] <= win_q[i+2];
      win_q[WIN_LEN-2] <= win_q[0];
      win_q[WIN_LEN-1] <= win_q[1];
    end
    if (prod_vld_q) begin
      if (prod_dft_q) begin
        case (prod_sel_q)
          2'd0: re_q <= re_q + prod_q[ACC_W-1:0];
          2'd1: re_q <= re_q - prod_q[ACC_W-1:0];
          default: im_q <= im_q + prod_q[ACC_W-1:0];
        endcase
      end else begin
        case (prod_sel_q)
          2'd0: sum_q <= sum_q + (SUM_W'(prod_q[MAG_W-1:0]) << 54);
          2'd1: sum_q <= sum_q + (SUM_W'(prod_q[MAG_W-1:0]) << 28);
          default: sum_q <= sum_q + SUM_W'(prod_q[MAG_W-1:0]);
        endcase
      end
    end
    // restoring square root, two radicand bits a step
    if (state_q == LN_ROOT) begin
      sum_q <= sum_q << 2;
      if (rem_sh >= trial) begin
        rem_q <= REM_W'(rem_sh - trial);
        root_q <= {root_q[MAG_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[REM_W-1:0];
        root_q <= {root_q[MAG_W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ rtl/ssbd_merge.sv @@
// strongest channel pick, one-shot flags and button toggles
module ssbd_merge import ssbd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             commit_i,
  input  logic [ACT_W-1:0] act_i [MAX_CH],
  input  logic [31:0]      thr_i,
  output merge_res_t       res_o
);

  logic [ACT_W-1:0] prev_q [MAX_CH];
  logic [ACT_W-1:0] prev_d [MAX_CH];
  logic [MAX_CH-1:0] armed_q, armed_d, tog_q, tog_d, toggled;
  logic lamp_q, lamp_d;
  logic [ACT_W-1:0] maxr;
  logic [CH_W-1:0] maxidx;

  always_comb begin
    maxr = '0;
    maxidx = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (act_i[c] > thr_i && act_i[c] > maxr) begin
        maxr = act_i[c];
        maxidx = CH_W'(c);
      end
    end
    armed_d = armed_q;
    tog_d = tog_q;
    lamp_d = lamp_q;
    toggled = '0;
    prev_d = prev_q;
    for (int c = 0; c < CHANNELS; c++) begin
      if (act_i[c] > thr_i && prev_q[c] > thr_i) begin
        // qualifying but not strongest keeps its history
        if (maxidx == CH_W'(c)) begin
          if (!armed_d[c]) begin
            armed_d[c] = 1'b1;
            tog_d[c] = ~tog_d[c];
            lamp_d = tog_d[c];
            toggled = '0;
            toggled[c] = 1'b1;
          end
          prev_d[c] = act_i[c];
        end
      end else begin
        if (act_i[c] <= thr_i && prev_q[c] <= thr_i) armed_d[c] = 1'b0;
        prev_d[c] = act_i[c];
      end
    end
    res_o.buttons = tog_d;
    res_o.toggled = toggled;
    res_o.lamp = lamp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < MAX_CH; c++) prev_q[c] <= '0;
      armed_q <= '0;
      tog_q <= '0;
      lamp_q <= 1'b0;
    end else if (commit_i) begin
      prev_q <= prev_d;
      armed_q <= armed_d;
      tog_q <= tog_d;
      lamp_q <= lamp_d;
    end
  end

endmodule

@@ rtl/spectral_swipe_button_detector.sv @@
// top level: stream ports, register port, lane control and result register
// result path: the input word is taken, then the bin 15 sums, squaring, 54 square-root steps,
//   the done state and the merge state, in which the result word is registered
// no new word is taken before the last is merged; each lane owns one multiplier and one root unit
// a result held by the sink stalls the merge and with it the next input word
// reset clears control, fill count and flags and sets the threshold to 8000; windows are not cleared
module spectral_swipe_button_detector import ssbd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // sample_ch0, sample_ch1, sample_ch2, sample_ch3
  input  logic [IN_W-1:0]    s_axis_tdata_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // activity_ch0..activity_ch3, button_states, toggled_mask, indicator_on, zero pad
  output logic [OUT_W-1:0]   m_axis_tdata_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  top_state_e state_q, state_d;
  logic [31:0] thr_q;
  logic [5:0] fill_q;
  logic full_q;
  logic out_vld_q;
  logic [OUT_W-1:0] out_q;
  logic in_acc, commit;
  logic [MAX_CH-1:0] done;
  logic [ACT_W-1:0] act [MAX_CH];
  merge_res_t res;

  for (genvar c = 0; c < MAX_CH; c++) begin : g_lane
    if (c < CHANNELS) begin : g_on
      ssbd_lane u_lane (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .start_i (in_acc),
        .sample_i(s_axis_tdata_i[c*SMP_W +: SMP_W]),
        .done_o  (done[c]),
        .act_o   (act[c])
      );
    end else begin : g_off
      assign done[c] = 1'b0;
      assign act[c] = '0;
    end
  end

  logic [ACT_W-1:0] act_m [MAX_CH];
  always_comb begin
    for (int c = 0; c < MAX_CH; c++) act_m[c] = full_q ? act[c] : '0;
  end

  ssbd_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .commit_i(commit),
    .act_i   (act_m),
    .thr_i   (thr_q),
    .res_o   (res)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (s_axis_tvalid_i) state_d = ST_BUSY;
      ST_BUSY:  if (done[0]) state_d = ST_MERGE;
      ST_MERGE: if (!out_vld_q || m_axis_tready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    in_acc = s_axis_tvalid_i && s_axis_tready_o;
    commit = (state_q == ST_MERGE) && (!out_vld_q || m_axis_tready_i);
    m_axis_tvalid_o = out_vld_q;
    m_axis_tdata_o = out_q;
    pready = 1'b1;
    prdata = (paddr[2] == REG_THRESH) ? thr_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      thr_q <= THRESH_RESET;
      fill_q <= '0;
      full_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (psel && penable && pwrite && pready && paddr[2] == REG_THRESH) thr_q <= pwdata;
      if (in_acc) begin
        if (fill_q != FILL_FULL) fill_q <= fill_q + 1'b1;
        full_q <= (fill_q >= FILL_LAST);
      end
      if (commit) out_vld_q <= 1'b1;
      else if (m_axis_tready_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_q <= {7'b0, res.lamp, res.toggled, res.buttons,
                act_m[3], act_m[2], act_m[1], act_m[0]};
    end
  end

endmodule

@@ rtl/ssbd_checker.sv @@
// port-level checks of the swipe button detector, bound to the top level
`include "assert_macros.svh"
module ssbd_checker import ssbd_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid_i,
  input logic               s_axis_tready_o,
  input logic               m_axis_tvalid_o,
  input logic               m_axis_tready_i,
  input logic [OUT_W-1:0]   m_axis_tdata_o,
  input logic               pready
);

  logic [3:0] tog_w, btn_w;
  logic       lamp_w, held, in_acc;

  assign tog_w  = m_axis_tdata_o[135:132];
  assign btn_w  = m_axis_tdata_o[131:128];
  assign lamp_w = m_axis_tdata_o[136];
  assign held   = m_axis_tvalid_o && !m_axis_tready_i;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // a held result word stays put
  `SSBD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, held, m_axis_tvalid_o && $stable(m_axis_tdata_o))
  // one word in flight at a time
  `SSBD_ASSERT_NXT(a_one_word, clk_i, rst_ni, in_acc, !s_axis_tready_o)
  // at most one button toggles per word
  `SSBD_ASSERT_NOW(a_one_toggle, clk_i, rst_ni, m_axis_tvalid_o, $onehot0(tog_w))
  // a toggled button shows its new state on the lamp
  `SSBD_ASSERT_NOW(a_lamp, clk_i, rst_ni, m_axis_tvalid_o && |tog_w, lamp_w == |(tog_w & btn_w))
  `SSBD_ASSERT_NOW(a_pready, clk_i, rst_ni, 1'b1, pready)

endmodule

bind spectral_swipe_button_detector ssbd_checker u_ssbd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .pready         (pready)
);

@@ tb/sv/testbench.sv @@
// stream testbench of the swipe button detector with its own bin-15 predictor
`timescale 1ns / 100ps

module testbench;
  import ssbd_pkg::*;

  typedef struct {
    bit [31:0] act [4];
    bit [3:0]  buttons;
    bit [3:0]  toggled;
    bit        lamp;
  } swipe_res_t;

  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 355;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_valid = 1'b0;
  logic [IN_W-1:0]    s_data = '0;
  logic               m_ready = 1'b0;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  wire                s_ready, m_valid, pready;
  wire [OUT_W-1:0]    m_data;
  wire [31:0]         prdata;

  spectral_swipe_button_detector i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready), .s_axis_tdata_i(s_data),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready), .m_axis_tdata_o(m_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [IN_W-1:0] pending_words [$];
  swipe_res_t      expected_res [$];
  int              idle_mode = 0;
  int              fails = 0;

  // predictor state
  bit [31:0] win [4][32];
  int        fill_cnt = 0;
  bit [31:0] prev_act [4] = '{default: 0};
  bit [3:0]  fired = 0, btn_state = 0;
  bit        lamp_q = 0;
  bit [31:0] thresh = 32'd8000;

  function automatic longint twiddle(int n);
    longint qc [5] = '{65536, 60547, 46341, 25080, 0};
    n = n & 15;
    if (n <= 4) return qc[n];
    if (n <= 8) return -qc[8 - n];
    if (n <= 12) return -qc[n - 8];
    return qc[16 - n];
  endfunction

  function automatic bit [31:0] bin15_mag(int ch);
    longint    re = 0, im = 0, a, b;
    bit [127:0] ar, ai, pwr, root = 0, cand;
    for (int n = 0; n < 16; n++) begin
      a = longint'(win[ch][2*n]);
      b = longint'(win[ch][2*n+1]);
      re += a * twiddle(n) - b * twiddle(n + 12);
      im += a * twiddle(n + 12) + b * twiddle(n);
    end
    ar = (re < 0) ? -re : re;
    ai = (im < 0) ? -im : im;
    pwr = ar * ar + ai * ai;
    // integer square root, then drop the q16 scale
    for (int bt = 54; bt >= 0; bt--) begin
      cand = root | (128'd1 << bt);
      if (cand * cand <= pwr) root = cand;
    end
    root = root >> 16;
    return (root > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
  endfunction

  function automatic void predict_swipe(logic [IN_W-1:0] d);
    swipe_res_t r;
    bit [31:0]  best = 0;
    int         best_ch = 0;
    for (int c = 0; c < 4; c++) begin
      for (int i = 1; i < 32; i++) win[c][i-1] = win[c][i];
      win[c][31] = d[32*c +: 32];
    end
    if (fill_cnt < 32) fill_cnt++;
    for (int c = 0; c < 4; c++) r.act[c] = (fill_cnt >= 32) ? bin15_mag(c) : 32'd0;
    for (int c = 0; c < 4; c++)
      if (r.act[c] > thresh && r.act[c] > best) begin
        best = r.act[c];
        best_ch = c;
      end
    r.toggled = 0;
    for (int c = 0; c < 4; c++) begin
      if (r.act[c] > thresh && prev_act[c] > thresh) begin
        // qualifying but not strongest keeps its history
        if (c != best_ch) continue;
        if (!fired[c]) begin
          fired[c] = 1'b1;
          btn_state[c] = ~btn_state[c];
          lamp_q = btn_state[c];
          r.toggled = 4'b1 << c;
        end
      end else if (r.act[c] <= thresh && prev_act[c] <= thresh) begin
        fired[c] = 1'b0;
      end
      prev_act[c] = r.act[c];
    end
    r.buttons = btn_state;
    r.lamp = lamp_q;
    expected_res.push_back(r);
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_valid || s_ready) begin
        if (pending_words.size() > 0 &&
            !((idle_mode == 1 || idle_mode == 3) &&
              $urandom_range(0, 99) < (idle_mode == 1 ? 87 : 31))) begin
          s_valid <= 1'b1;
          s_data <= pending_words.pop_front();
        end else begin
          s_valid <= 1'b0;
        end
      end
      if (idle_mode == 2) m_ready <= ($urandom_range(0, 99) >= 87);
      else if (idle_mode == 3) m_ready <= ($urandom_range(0, 99) >= 31);
      else m_ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    swipe_res_t e;
    if (rst_ni) begin
      if (s_valid && s_ready) predict_swipe(s_data);
      if (m_valid && m_ready) begin
        if (expected_res.size() == 0) begin
          $error("result word with nothing expected");
          fails++;
        end else begin
          e = expected_res.pop_front();
          for (int c = 0; c < 4; c++)
            if (m_data[32*c +: 32] !== e.act[c]) begin
              $error("activity_ch%0d expected %0d got %0d", c, e.act[c], m_data[32*c +: 32]);
              fails++;
            end
          if (m_data[131:128] !== e.buttons) begin
            $error("button_states expected %h got %h", e.buttons, m_data[131:128]);
            fails++;
          end
          if (m_data[135:132] !== e.toggled) begin
            $error("toggled_mask expected %h got %h", e.toggled, m_data[135:132]);
            fails++;
          end
          if (m_data[136] !== e.lamp) begin
            $error("indicator_on expected %b got %b", e.lamp, m_data[136]);
            fails++;
          end
        end
      end
    end
  end

  task automatic write_thresh(bit [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_THRESH, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    thresh = v;
  endtask

  function automatic logic [IN_W-1:0] pack4(bit [31:0] a, bit [31:0] b, bit [31:0] c,
                                            bit [31:0] d);
    return {d, c, b, a};
  endfunction

  // one swipe, tie run, quiet run or noise burst
  function automatic int queue_segment();
    int         len, kind, lvl;
    bit [3:0]   hot;
    bit [31:0]  v [4];
    kind = $urandom_range(0, 99);
    len = $urandom_range(5, 45);
    hot = 4'b1 << $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) hot |= 4'b1 << $urandom_range(0, 3);
    lvl = $urandom_range(0, 2);
    for (int k = 0; k < len; k++) begin
      for (int c = 0; c < 4; c++) begin
        if (kind < 15) v[c] = $urandom;
        else if (kind < 55 && hot[c])
          v[c] = (lvl == 0) ? $urandom : (lvl == 1) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 4095);
        else v[c] = $urandom_range(0, 255);
      end
      if (kind >= 95) v[1] = v[0];
      if (kind >= 95) begin
        v[2] = v[0];
        v[3] = v[0];
      end
      pending_words.push_back(pack4(v[0], v[1], v[2], v[3]));
    end
    return len;
  endfunction

  initial begin
    int        made;
    bit [31:0] th_list [PHASES];
    int        mode_list [PHASES];
    mode_list = '{0, 1, 2, 3, 0};
    th_list = '{32'd8000, 32'd0, 32'hFFFF_FFFF, $urandom_range(1000, 2000000), $urandom};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, mixed bit patterns, then equal channels for ties
    for (int k = 0; k < 4; k++) pending_words.push_back('0);
    for (int k = 0; k < 4; k++) pending_words.push_back({IN_W{1'b1}});
    for (int k = 0; k < 4; k++)
      pending_words.push_back(pack4(32'h8000_0001 << k, 32'h5555_5555, 32'hAAAA_AAAA, k));
    for (int k = 0; k < 12; k++) begin
      bit [31:0] t;
      t = (k % 4 < 2) ? 32'hFFFF_FFFF : 32'd0;
      pending_words.push_back(pack4(t, t, t, t));
    end
    for (int p = 0; p < PHASES; p++) begin
      wait (pending_words.size() == 0 && expected_res.size() == 0 && !s_valid);
      repeat (150) @(posedge clk_i);
      if (p > 0) write_thresh(th_list[p]);
      idle_mode = mode_list[p];
      made = 0;
      while (made < PHASE_ITEMS) made += queue_segment();
    end
    wait (pending_words.size() == 0 && !s_valid);
    wait (expected_res.size() == 0);
    repeat (200) @(posedge clk_i);
    if (fails == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
